/* src/c8ie_pkg.sv */
// Shared types and constants for the CHIP-8 instruction execute block.
package c8ie_pkg;

  localparam int MemDepth   = 4096;
  localparam int AddrW      = $clog2(MemDepth);
  localparam int StackDepth = 16;
  localparam int StackW     = $clog2(StackDepth);
  localparam int SdW        = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_REG  = 2'd1,
    KIND_MEM  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_STACK   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_UNSUPP  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BCD,
    S_STORE_RD,
    S_STORE_WR,
    S_LOAD_RD,
    S_LOAD_WAIT,
    S_LOAD_WR,
    S_EMIT,
    S_EMIT2,
    S_OUT
  } state_t;

  // Result word handed to the output register.
  typedef struct packed {
    kind_t       kind;
    logic [11:0] target;
    logic [7:0]  value;
    logic        last;
  } res_t;

endpackage

/* src/chip8_instruction_execute.sv */
// Top level of the CHIP-8 instruction execute block.
// One word in, then one to sixteen result words out, one per register or memory
// write in order (a single word of kind none if nothing is written), the final one
// marked by last. BCD store finds each digit by repeated subtraction; block store
// and load move one register at a time through the memory. Every result word leaves
// through one output register, and a result word waits there until taken. The block
// takes the next word as soon as the last result of the previous one sits in that
// register.
module chip8_instruction_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        font_base_we,
  input  logic [11:0] font_base_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] instr_word,
  input  logic [7:0]  random_value,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  write_kind,
  output logic [11:0] write_target,
  output logic [7:0]  write_value,
  output logic [11:0] next_pc,
  output logic [15:0] index_value,
  output logic [2:0]  status,
  output logic        last
);

  localparam int AW = c8ie_pkg::AddrW;

  typedef logic [c8ie_pkg::StackW-1:0] StackIdx;

  c8ie_pkg::state_t state, state_next;

  logic [11:0] font_base;
  logic [7:0]  gp_regs [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [c8ie_pkg::SdW-1:0] sp;
  logic [11:0] rstack [c8ie_pkg::StackDepth];
  logic [7:0]  delay_count, sound_count;

  logic        op_q;
  logic [15:0] iw;
  logic [7:0]  rnd;
  logic [11:0] la;
  logic [7:0]  lv;

  // sequencer work registers
  logic [3:0]  cnt, cnt_next;
  logic [7:0]  acc, acc_next;
  logic [1:0]  digit, digit_next;

  // output register
  logic             ovalid;
  c8ie_pkg::res_t   ores;
  logic [2:0]       ostatus;
  logic [11:0]      res_pc;
  logic [15:0]      res_index;
  logic [2:0]       res_status;

  c8ie_pkg::res_t r1_q, r2_q;
  logic [7:0]     random_value_q;
  assign random_value_q = rnd;

  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn;
  assign x   = iw[11:8];
  assign y   = iw[7:4];
  assign n   = iw[3:0];
  assign nn  = iw[7:0];
  assign nnn = iw[11:0];
  assign vx  = gp_regs[x];
  assign vy  = gp_regs[y];

  logic [16:0] end_addr;
  assign end_addr = {1'b0, ireg} + ((iw[7:0] == 8'h33) ? 17'd2 : {13'd0, x});
  logic range_bad;
  assign range_bad = end_addr >= 17'(c8ie_pkg::MemDepth);

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic [11:0]   mem_waddr_ext;
  assign mem_waddr_ext = 12'(mem_waddr);

  c8ie_mem u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  logic [16:0] cur_addr;
  assign cur_addr  = {1'b0, ireg} + {13'd0, cnt};
  assign mem_raddr = cur_addr[AW-1:0];

  logic load_in_range;
  assign load_in_range = {5'd0, la} < 17'(c8ie_pkg::MemDepth);

  // combinational decode results
  c8ie_pkg::res_t r1, r2;
  logic           two;
  logic [11:0]    pc_new;
  logic [15:0]    i_new;
  logic [2:0]     st_new;
  logic           push, pop;
  logic           set_delay, set_sound;
  c8ie_pkg::state_t dec_go;
  logic [8:0]     sum9;
  logic [11:0]    pc2;

  always_comb begin
    pc2       = pc + 12'd2;
    pc_new    = pc2;
    i_new     = ireg;
    st_new    = c8ie_pkg::ST_OK;
    r1        = '{c8ie_pkg::KIND_NONE, 12'd0, 8'd0, 1'b1};
    r2        = '{c8ie_pkg::KIND_REG, 12'd15, 8'd0, 1'b1};
    two       = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    set_delay = 1'b0;
    set_sound = 1'b0;
    dec_go    = c8ie_pkg::S_EMIT;
    sum9      = 9'd0;
    unique case (iw[15:12])
      4'h0: begin
        if (iw == 16'h00E0) begin
          st_new = c8ie_pkg::ST_UNSUPP;
        end else if (iw == 16'h00EE) begin
          if (sp == '0) begin
            st_new = c8ie_pkg::ST_STACK;
          end else begin
            pop    = 1'b1;
            pc_new = rstack[StackIdx'(sp - 1'b1)];
          end
        end else begin
          st_new = c8ie_pkg::ST_UNKNOWN;
        end
      end
      4'h1: pc_new = nnn;
      4'h2: begin
        if (sp >= c8ie_pkg::SdW'(c8ie_pkg::StackDepth)) begin
          st_new = c8ie_pkg::ST_STACK;
        end else begin
          push   = 1'b1;
          pc_new = nnn;
        end
      end
      4'h3: if (vx == nn) pc_new = pc2 + 12'd2;
      4'h4: if (vx != nn) pc_new = pc2 + 12'd2;
      4'h5: begin
        if (n != 4'd0) st_new = c8ie_pkg::ST_UNKNOWN;
        else if (vx == vy) pc_new = pc2 + 12'd2;
      end
      4'h6: r1 = '{c8ie_pkg::KIND_REG, {8'd0, x}, nn, 1'b1};
      4'h7: r1 = '{c8ie_pkg::KIND_REG, {8'd0, x}, vx + nn, 1'b1};
      4'h8: begin
        r1.kind   = c8ie_pkg::KIND_REG;
        r1.target = {8'd0, x};
        case (n)
          4'h0: r1.value = vy;
          4'h1: r1.value = vx | vy;
          4'h2: r1.value = vx & vy;
          4'h3: r1.value = vx ^ vy;
          4'h4: begin
            sum9     = {1'b0, vx} + {1'b0, vy};
            r1.value = sum9[7:0];
            r2.value = {7'd0, sum9[8]};
            two      = 1'b1;
          end
          4'h5: begin
            r1.value = vx - vy;
            r2.value = {7'd0, vx > vy};
            two      = 1'b1;
          end
          4'h6: begin
            r1.value = {1'b0, vy[7:1]};
            r2.value = {7'd0, vy[0]};
            two      = 1'b1;
          end
          4'h7: begin
            r1.value = vy - vx;
            r2.value = {7'd0, vy > vx};
            two      = 1'b1;
          end
          4'hE: begin
            r1.value = {vy[6:0], 1'b0};
            r2.value = {7'd0, vy[7]};
            two      = 1'b1;
          end
          default: begin
            r1     = '{c8ie_pkg::KIND_NONE, 12'd0, 8'd0, 1'b1};
            st_new = c8ie_pkg::ST_UNKNOWN;
          end
        endcase
        r1.last = !two;
      end
      4'h9: begin
        if (n != 4'd0) st_new = c8ie_pkg::ST_UNKNOWN;
        else if (vx != vy) pc_new = pc2 + 12'd2;
      end
      4'hA: i_new = {4'd0, nnn};
      4'hB: pc_new = nnn + {4'd0, gp_regs[0]};
      4'hC: r1 = '{c8ie_pkg::KIND_REG, {8'd0, x}, random_value_q & nn, 1'b1};
      4'hD: st_new = c8ie_pkg::ST_UNSUPP;
      4'hE: st_new = (nn == 8'h9E || nn == 8'hA1) ? c8ie_pkg::ST_UNSUPP
                                                  : c8ie_pkg::ST_UNKNOWN;
      4'hF: begin
        case (nn)
          8'h07: r1 = '{c8ie_pkg::KIND_REG, {8'd0, x}, delay_count, 1'b1};
          8'h0A: st_new = c8ie_pkg::ST_UNSUPP;
          8'h15: set_delay = 1'b1;
          8'h18: set_sound = 1'b1;
          8'h1E: i_new = ireg + {8'd0, vx};
          8'h29: i_new = {4'd0, font_base} + {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
          8'h33: begin
            if (range_bad) st_new = c8ie_pkg::ST_RANGE;
            else dec_go = c8ie_pkg::S_BCD;
          end
          8'h55: begin
            if (range_bad) st_new = c8ie_pkg::ST_RANGE;
            else dec_go = c8ie_pkg::S_STORE_WR;
          end
          8'h65: begin
            if (range_bad) st_new = c8ie_pkg::ST_RANGE;
            else dec_go = c8ie_pkg::S_LOAD_RD;
          end
          default: st_new = c8ie_pkg::ST_UNKNOWN;
        endcase
      end
      default: ;
    endcase
  end

  // BCD digit extraction: repeated subtraction of 100, then of 10
  logic [7:0] sub_k;
  logic       sub_ge;
  assign sub_k  = (digit == 2'd0) ? 8'd100 : 8'd10;
  assign sub_ge = acc >= sub_k;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    acc_next   = acc;
    digit_next = digit;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr[AW-1:0];
    mem_wdata  = 8'd0;
    unique case (state)
      c8ie_pkg::S_IDLE: begin
        if (in_valid && in_ready) state_next = c8ie_pkg::S_DECODE;
        cnt_next = '0;
      end
      c8ie_pkg::S_DECODE: begin
        if (op_q) state_next = c8ie_pkg::S_OUT;
        else state_next = dec_go;
        cnt_next   = '0;
        acc_next   = vx;
        digit_next = 2'd0;
      end
      c8ie_pkg::S_BCD: begin
        if (digit == 2'd2) begin
          mem_we    = ovalid ? 1'b0 : 1'b1;
          mem_wdata = acc;
          if (!ovalid) state_next = c8ie_pkg::S_IDLE;
        end else if (sub_ge) begin
          acc_next = acc - sub_k;
          cnt_next = cnt + 4'd1;
        end else if (!ovalid) begin
          mem_we     = 1'b1;
          mem_waddr  = AW'({1'b0, ireg} + {15'd0, digit});
          mem_wdata  = {4'd0, cnt};
          digit_next = digit + 2'd1;
          cnt_next   = '0;
        end
        if (digit == 2'd2) mem_waddr = AW'({1'b0, ireg} + 17'd2);
      end
      c8ie_pkg::S_STORE_WR: begin
        if (!ovalid) begin
          mem_we    = 1'b1;
          mem_wdata = gp_regs[cnt];
          cnt_next  = cnt + 4'd1;
          if (cnt == x) state_next = c8ie_pkg::S_IDLE;
        end
      end
      c8ie_pkg::S_LOAD_RD: state_next = c8ie_pkg::S_LOAD_WAIT;
      c8ie_pkg::S_LOAD_WAIT: state_next = c8ie_pkg::S_LOAD_WR;
      c8ie_pkg::S_LOAD_WR: begin
        if (!ovalid) begin
          cnt_next = cnt + 4'd1;
          state_next = (cnt == x) ? c8ie_pkg::S_IDLE : c8ie_pkg::S_LOAD_RD;
        end
      end
      c8ie_pkg::S_EMIT: if (!ovalid) state_next = two ? c8ie_pkg::S_EMIT2
                                                       : c8ie_pkg::S_IDLE;
      c8ie_pkg::S_EMIT2: if (!ovalid) state_next = c8ie_pkg::S_IDLE;
      c8ie_pkg::S_OUT: begin
        if (!ovalid) begin
          mem_we    = load_in_range;
          mem_waddr = AW'(la);
          mem_wdata = lv;
          state_next = c8ie_pkg::S_IDLE;
        end
      end
      default: state_next = c8ie_pkg::S_IDLE;
    endcase
  end

  assign in_ready = (state == c8ie_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= c8ie_pkg::S_IDLE;
      font_base   <= 12'd80;
      ireg        <= '0;
      pc          <= 12'd512;
      sp          <= '0;
      delay_count <= '0;
      sound_count <= '0;
      ovalid      <= 1'b0;
      ostatus     <= c8ie_pkg::ST_OK;
      for (int i = 0; i < 16; i++) gp_regs[i] <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      acc   <= acc_next;
      digit <= digit_next;
      if (font_base_we) font_base <= font_base_wdata;
      if (ovalid && out_ready) ovalid <= 1'b0;

      if (in_valid && in_ready) begin
        op_q <= operation;
        iw   <= instr_word;
        rnd  <= random_value;
        la   <= load_address;
        lv   <= load_value;
      end

      unique case (state)
        c8ie_pkg::S_DECODE: begin
          if (!op_q) begin
            pc      <= pc_new;
            ireg    <= i_new;
            ostatus <= st_new;
            if (push) begin
              rstack[StackIdx'(sp)] <= pc2;
              sp <= sp + 1'b1;
            end
            if (pop) sp <= sp - 1'b1;
            if (set_delay) delay_count <= vx;
            if (set_sound) sound_count <= vx;
            r1_q <= r1;
            r2_q <= r2;
          end
        end
        c8ie_pkg::S_EMIT: if (!ovalid) begin
          ovalid     <= 1'b1;
          ores       <= r1_q;
          res_pc     <= pc;
          res_index  <= ireg;
          res_status <= ostatus;
          if (r1_q.kind == c8ie_pkg::KIND_REG) gp_regs[r1_q.target[3:0]] <= r1_q.value;
        end
        c8ie_pkg::S_EMIT2: if (!ovalid) begin
          ovalid      <= 1'b1;
          ores        <= r2_q;
          res_pc      <= pc;
          res_index   <= ireg;
          res_status  <= ostatus;
          gp_regs[15] <= r2_q.value;
        end
        c8ie_pkg::S_BCD: if (!ovalid && (digit == 2'd2 || !sub_ge)) begin
          ovalid     <= 1'b1;
          ores       <= '{c8ie_pkg::KIND_MEM, mem_waddr_ext, mem_wdata, digit == 2'd2};
          res_pc     <= pc;
          res_index  <= ireg;
          res_status <= ostatus;
        end
        c8ie_pkg::S_STORE_WR: if (!ovalid) begin
          ovalid     <= 1'b1;
          ores       <= '{c8ie_pkg::KIND_MEM, cur_addr[11:0], gp_regs[cnt], cnt == x};
          res_pc     <= pc;
          res_index  <= ireg;
          res_status <= ostatus;
        end
        c8ie_pkg::S_LOAD_WR: if (!ovalid) begin
          ovalid       <= 1'b1;
          ores         <= '{c8ie_pkg::KIND_REG, {8'd0, cnt}, mem_rdata, cnt == x};
          res_pc       <= pc;
          res_index    <= ireg;
          res_status   <= ostatus;
          gp_regs[cnt] <= mem_rdata;
        end
        c8ie_pkg::S_OUT: if (!ovalid) begin
          ovalid    <= 1'b1;
          res_pc    <= pc;
          res_index <= ireg;
          if (load_in_range) begin
            ores       <= '{c8ie_pkg::KIND_MEM, la, lv, 1'b1};
            res_status <= c8ie_pkg::ST_OK;
          end else begin
            ores       <= '{c8ie_pkg::KIND_NONE, 12'd0, 8'd0, 1'b1};
            res_status <= c8ie_pkg::ST_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = ovalid;
  assign write_kind   = ores.kind;
  assign write_target = ores.target;
  assign write_value  = ores.value;
  assign last         = ores.last;
  assign next_pc      = res_pc;
  assign index_value  = res_index;
  assign status       = res_status;

endmodule

/* src/c8ie_mem.sv */
// Program memory: one write port, one registered read port.
module c8ie_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [c8ie_pkg::AddrW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [c8ie_pkg::AddrW-1:0] raddr,
  output logic [7:0]                rdata
);

  logic [7:0] mem [c8ie_pkg::MemDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/c8ie_checker.sv */
// Predictor and result checker for the CHIP-8 instruction execute block.
`timescale 1ns / 100ps
module c8ie_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        font_base_we,
  input  logic [11:0] font_base_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [15:0] instr_word,
  input  logic [7:0]  random_value,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  write_kind,
  input  logic [11:0] write_target,
  input  logic [7:0]  write_value,
  input  logic [11:0] next_pc,
  input  logic [15:0] index_value,
  input  logic [2:0]  status,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    c8ie_pkg::kind_t   kind;
    logic [11:0]       target;
    logic [7:0]        value;
    logic [11:0]       pc;
    logic [15:0]       idx;
    c8ie_pkg::status_t st;
    logic              last;
  } chip_write_t;

  chip_write_t expected_writes[$];
  chip_write_t item_writes[$];

  logic [7:0]  v[16];
  logic [15:0] ireg;
  logic [11:0] pc;
  int          sp;
  logic [11:0] ret_stack[c8ie_pkg::StackDepth];
  logic [7:0]  delay_count;
  logic [7:0]  sound_count;
  logic [7:0]  mem[c8ie_pkg::MemDepth];
  logic [11:0] font_base;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void note(input c8ie_pkg::kind_t k, input int tgt,
                               input logic [7:0] val);
    chip_write_t w;
    w.kind = k;
    w.target = tgt[11:0];
    w.value = val;
    item_writes.push_back(w);
  endfunction

  function automatic void set_reg(input int r, input logic [7:0] val);
    v[r] = val;
    note(c8ie_pkg::KIND_REG, r, val);
  endfunction

  function automatic void set_mem(input int a, input logic [7:0] val);
    mem[a] = val;
    note(c8ie_pkg::KIND_MEM, a, val);
  endfunction

  function automatic c8ie_pkg::status_t run_instruction(input logic [15:0] op,
                                                        input logic [7:0] rnd);
    int x, y, nib, a;
    logic [7:0] nn, vx, vy;
    logic [11:0] nnn, npc;
    logic [8:0] sum;
    c8ie_pkg::status_t st;
    bit skip;
    x = op[11:8];
    y = op[7:4];
    nib = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    vx = v[x];
    vy = v[y];
    npc = pc + 12'd2;
    st = c8ie_pkg::ST_OK;
    skip = 0;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) st = c8ie_pkg::ST_UNSUPP;
        else if (op == 16'h00EE) begin
          if (sp == 0) st = c8ie_pkg::ST_STACK;
          else begin
            sp--;
            npc = ret_stack[sp];
          end
        end else st = c8ie_pkg::ST_UNKNOWN;
      end
      4'h1: npc = nnn;
      4'h2: begin
        if (sp >= c8ie_pkg::StackDepth) st = c8ie_pkg::ST_STACK;
        else begin
          ret_stack[sp] = npc;
          sp++;
          npc = nnn;
        end
      end
      4'h3: skip = (vx == nn);
      4'h4: skip = (vx != nn);
      4'h5: if (nib != 0) st = c8ie_pkg::ST_UNKNOWN; else skip = (vx == vy);
      4'h6: set_reg(x, nn);
      4'h7: set_reg(x, vx + nn);
      4'h8: begin
        case (nib)
          0: set_reg(x, vy);
          1: set_reg(x, vx | vy);
          2: set_reg(x, vx & vy);
          3: set_reg(x, vx ^ vy);
          4: begin
            sum = vx + vy;
            set_reg(x, sum[7:0]);
            set_reg(15, {7'd0, sum[8]});
          end
          5: begin
            set_reg(x, vx - vy);
            set_reg(15, {7'd0, vx > vy});
          end
          6: begin
            set_reg(x, vy >> 1);
            set_reg(15, {7'd0, vy[0]});
          end
          7: begin
            set_reg(x, vy - vx);
            set_reg(15, {7'd0, vy > vx});
          end
          14: begin
            set_reg(x, vy << 1);
            set_reg(15, {7'd0, vy[7]});
          end
          default: st = c8ie_pkg::ST_UNKNOWN;
        endcase
      end
      4'h9: if (nib != 0) st = c8ie_pkg::ST_UNKNOWN; else skip = (vx != vy);
      4'hA: ireg = {4'd0, nnn};
      4'hB: npc = nnn + {4'd0, v[0]};
      4'hC: set_reg(x, rnd & nn);
      4'hD: st = c8ie_pkg::ST_UNSUPP;
      4'hE: st = (nn == 8'h9E || nn == 8'hA1) ? c8ie_pkg::ST_UNSUPP
                                              : c8ie_pkg::ST_UNKNOWN;
      default: begin
        case (nn)
          8'h07: set_reg(x, delay_count);
          8'h0A: st = c8ie_pkg::ST_UNSUPP;
          8'h15: delay_count = vx;
          8'h18: sound_count = vx;
          8'h1E: ireg = ireg + {8'd0, vx};
          8'h29: ireg = {4'd0, font_base} + 16'(vx[3:0]) * 16'd5;
          8'h33: begin
            if (int'(ireg) + 2 >= c8ie_pkg::MemDepth) st = c8ie_pkg::ST_RANGE;
            else begin
              set_mem(ireg, vx / 100);
              set_mem(ireg + 1, (vx / 10) % 10);
              set_mem(ireg + 2, vx % 10);
            end
          end
          8'h55: begin
            if (int'(ireg) + x >= c8ie_pkg::MemDepth) st = c8ie_pkg::ST_RANGE;
            else for (a = 0; a <= x; a++) set_mem(ireg + a, v[a]);
          end
          8'h65: begin
            if (int'(ireg) + x >= c8ie_pkg::MemDepth) st = c8ie_pkg::ST_RANGE;
            else for (a = 0; a <= x; a++) set_reg(a, mem[ireg + a]);
          end
          default: st = c8ie_pkg::ST_UNKNOWN;
        endcase
      end
    endcase
    if (skip) npc = npc + 12'd2;
    pc = npc;
    return st;
  endfunction

  function automatic void predict_item();
    c8ie_pkg::status_t st;
    int k;
    chip_write_t w;
    item_writes.delete();
    st = c8ie_pkg::ST_OK;
    if (operation) set_mem(load_address, load_value);
    else st = run_instruction(instr_word, random_value);
    if (item_writes.size() == 0) note(c8ie_pkg::KIND_NONE, 0, 8'd0);
    for (k = 0; k < item_writes.size(); k++) begin
      w = item_writes[k];
      w.pc = pc;
      w.idx = ireg;
      w.st = st;
      w.last = (k == item_writes.size() - 1);
      expected_writes.push_back(w);
    end
  endfunction

  task automatic check_word();
    chip_write_t w;
    if (expected_writes.size() == 0) begin
      report($sformatf("unexpected result word kind=%0d", write_kind));
      return;
    end
    w = expected_writes.pop_front();
    if (write_kind !== w.kind)
      report($sformatf("write_kind %0d, want %0d", write_kind, w.kind));
    if (write_target !== w.target)
      report($sformatf("write_target %0h, want %0h", write_target, w.target));
    if (write_value !== w.value)
      report($sformatf("write_value %0h, want %0h", write_value, w.value));
    if (next_pc !== w.pc)
      report($sformatf("next_pc %0h, want %0h", next_pc, w.pc));
    if (index_value !== w.idx)
      report($sformatf("index_value %0h, want %0h", index_value, w.idx));
    if (status !== w.st)
      report($sformatf("status %0d, want %0d", status, w.st));
    if (last !== w.last)
      report($sformatf("last %0b, want %0b", last, w.last));
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (v[r]) v[r] = 8'd0;
      ireg = 16'd0;
      pc = 12'd512;
      sp = 0;
      delay_count = 8'd0;
      sound_count = 8'd0;
      font_base = 12'd80;
      expected_writes.delete();
    end else begin
      if (out_valid && out_ready) check_word();
      if (font_base_we) font_base = font_base_wdata;
      if (in_valid && in_ready) predict_item();
    end
    pending = expected_writes.size();
  end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the CHIP-8 instruction execute block.
`timescale 1ns / 100ps
module testbench;

  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        font_base_we = 1'b0;
  logic [11:0] font_base_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [15:0] instr_word = '0;
  logic [7:0]  random_value = '0;
  logic [11:0] load_address = '0;
  logic [7:0]  load_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  write_kind;
  logic [11:0] write_target;
  logic [7:0]  write_value;
  logic [11:0] next_pc;
  logic [15:0] index_value;
  logic [2:0]  status;
  logic        last;
  int          fail_count;
  int          pending;
  bit          sink_hold = 0;
  bit          no_idle = 0;
  int          quiet_cycles = 0;

  bit          written[c8ie_pkg::MemDepth];
  logic [15:0] shadow_i;
  int          shadow_sp;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chip8_instruction_execute u_dut (.*);

  c8ie_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || sink_hold) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input bit op, input logic [15:0] ins, input logic [7:0] rnd,
                           input logic [11:0] addr, input logic [7:0] val);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    instr_word <= ins;
    random_value <= rnd;
    load_address <= addr;
    load_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_byte(input int addr, input logic [7:0] val);
    written[addr] = 1;
    send_word(1'b1, 16'h0000, 8'd0, addr[11:0], val);
  endtask

  // Track I and stack depth so that reads stay on written memory and calls balance.
  task automatic exec_op(input logic [15:0] ins);
    int x, a;
    x = ins[11:8];
    if (ins[15:12] == 4'hA) shadow_i = {4'd0, ins[11:0]};
    if (ins[15:12] == 4'hF && ins[7:0] inside {8'h1E, 8'h29}) shadow_i = 16'hFFFF;
    if (ins[15:12] == 4'hF && ins[7:0] == 8'h33 &&
        int'(shadow_i) + 2 < c8ie_pkg::MemDepth)
      for (a = 0; a < 3; a++) written[shadow_i + a] = 1;
    if (ins[15:12] == 4'hF && ins[7:0] == 8'h55 &&
        int'(shadow_i) + x < c8ie_pkg::MemDepth)
      for (a = 0; a <= x; a++) written[shadow_i + a] = 1;
    if (ins[15:12] == 4'hF && ins[7:0] == 8'h65 && shadow_i == 16'hFFFF)
      ins[7:0] = 8'h55;
    if (ins[15:12] == 4'hF && ins[7:0] == 8'h65 &&
        int'(shadow_i) + x < c8ie_pkg::MemDepth)
      for (a = 0; a <= x; a++)
        if (!written[shadow_i + a]) ins[7:0] = 8'h55;
    if (ins[15:12] == 4'h2 && shadow_sp < c8ie_pkg::StackDepth) shadow_sp++;
    if (ins == 16'h00EE && shadow_sp > 0) shadow_sp--;
    send_word(1'b0, ins, 8'($urandom), 12'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_font_base(input logic [11:0] val);
    drain();
    font_base_we <= 1'b1;
    font_base_wdata <= val;
    @(posedge clk);
    font_base_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick, x, base;
    pick = $urandom_range(99);
    x = $urandom_range(15);
    if (pick < 10) load_byte($urandom_range(4095), 8'($urandom));
    else if (pick < 20) begin
      base = $urandom_range(4095);
      exec_op({4'hA, base[11:0]});
      exec_op({4'hF, x[3:0], 8'h55});
      exec_op({4'hF, x[3:0], 8'h65});
    end else if (pick < 26) begin
      exec_op({4'hA, 12'($urandom_range(4095))});
      exec_op({4'hF, x[3:0], 8'h33});
    end else if (pick < 34) begin
      exec_op({4'h2, 12'($urandom)});
      exec_op(16'h00EE);
    end else if (pick < 38 && shadow_sp > 0) exec_op(16'h00EE);
    else if (pick < 60) exec_op({4'h8, x[3:0], 4'($urandom), 4'($urandom)});
    else if (pick < 75) exec_op({4'($urandom_range(3, 7)), 12'($urandom)});
    else exec_op(16'($urandom));
  endtask

  initial begin
    int k;
    shadow_i = 16'd0;
    shadow_sp = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    exec_op(16'h00E0);
    exec_op(16'h00EE);
    exec_op(16'h0123);
    exec_op(16'h60FF);
    exec_op(16'h6F01);
    exec_op(16'h7001);
    exec_op(16'h30FF);
    exec_op(16'h4000);
    exec_op(16'h5101);
    exec_op(16'h9010);
    exec_op(16'h61FF);
    exec_op(16'h8014);
    exec_op(16'h8F15);
    exec_op(16'h8016);
    exec_op(16'h801E);
    exec_op(16'h8017);
    exec_op(16'h8018);
    exec_op(16'hB0FF);
    exec_op(16'hCFFF);
    exec_op(16'hD123);
    exec_op(16'hE19E);
    exec_op(16'hE1A1);
    exec_op(16'hF00A);
    exec_op(16'hF115);
    exec_op(16'hF218);
    exec_op(16'hF307);
    exec_op(16'hF1FF);
    exec_op(16'hAFFE);
    exec_op(16'hF033);
    exec_op(16'hF11E);
    exec_op(16'hA000);
    exec_op(16'hFF55);
    exec_op(16'hFF65);
    load_byte(4095, 8'hFF);
    exec_op(16'hF129);
    for (k = 0; k < 17; k++) exec_op(16'h2FFF);
    for (k = 0; k < 17; k++) exec_op(16'h00EE);

    write_font_base(12'd0);
    exec_op(16'hF129);
    write_font_base(12'hFFF);
    exec_op(16'hF129);

    // Hold the sink so the block backs up.
    sink_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        sink_hold = 0;
      end
      for (k = 0; k < 5; k++) random_item();
    join

    no_idle = 1;
    for (k = 0; k < 40; k++) random_item();
    no_idle = 0;
    drain();

    for (k = 0; k < 60; k++) random_item();
    write_font_base(12'($urandom));
    for (k = 0; k < 60; k++) random_item();
    write_font_base(12'd80);
    for (k = 0; k < 40; k++) random_item();

    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/c8ie_pkg.sv
src/c8ie_mem.sv
src/chip8_instruction_execute.sv
tb/c8ie_checker.sv
tb/testbench.sv
